[src/access_rule_table_core_assert.svh]
// Assertion macros shared by the access rule table modules.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef ACCESS_RULE_TABLE_CORE_ASSERT_SVH
`define ACCESS_RULE_TABLE_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define ARC_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define ARC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/arc_pkg.sv]
// Shared types and constants for the access rule table.
// No dependencies; used by every module of the block but arc_ram.
`default_nettype none

package arc_pkg;

  localparam int unsigned ENTRIES_DEF    = 16;
  localparam int unsigned KEY_BITS_DEF   = 256;
  localparam int unsigned RIGHT_BITS_DEF = 4;

  localparam int unsigned KIND_W      = 3;
  localparam int unsigned KEY_IN_W    = 256;
  localparam int unsigned RIGHT_IN_W  = 4;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned KEY_LSB     = 0;
  localparam int unsigned RIGHT_LSB   = KEY_LSB + KEY_IN_W;
  localparam int unsigned IN_TDATA_W  = 264;
  localparam int unsigned OUT_TDATA_W = 8;
  localparam int unsigned OUT_PAD_W   = OUT_TDATA_W - STATUS_W - 1;

  typedef enum logic [KIND_W-1:0] {
    KIND_ADD_ID   = 3'd0,
    KIND_ADD_WILD = 3'd1,
    KIND_REMOVE   = 3'd2,
    KIND_QUERY    = 3'd3,
    KIND_CLEAR    = 3'd4
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_DUP       = 2'd1,
    STATUS_NOT_FOUND = 2'd2,
    STATUS_FULL      = 2'd3
  } status_e;

  typedef struct packed {
    logic load;    // capture request, clear scan flags
    logic rd;      // read entry at scan index
    logic commit;  // update table, load result
  } arc_cmd_t;

  typedef struct packed {
    logic out_free;  // result register can take a new result
  } arc_stat_t;

endpackage

`default_nettype wire

[src/arc_ram.sv]
// Generic simple dual-port RAM with registered read.
// No dependencies.
`default_nettype none

module arc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[src/arc_datapath.sv]
// Datapath of the access rule table: request registers, key RAM, entry flags,
// scan compare stage and result register. Depends on arc_pkg and arc_ram.
`default_nettype none

`include "access_rule_table_core_assert.svh"

module arc_datapath #(
  parameter int unsigned ENTRIES    = arc_pkg::ENTRIES_DEF,
  parameter int unsigned KEY_BITS   = arc_pkg::KEY_BITS_DEF,
  parameter int unsigned RIGHT_BITS = arc_pkg::RIGHT_BITS_DEF,
  parameter int unsigned IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire arc_pkg::arc_cmd_t                cmd_i,
  input  wire logic [IDX_W-1:0]                 idx_i,
  input  wire logic [arc_pkg::IN_TDATA_W-1:0]   s_tdata_i,
  input  wire logic [arc_pkg::KIND_W-1:0]       s_tuser_i,
  output logic                                  m_tvalid_o,
  input  wire logic                             m_tready_i,
  output logic [arc_pkg::OUT_TDATA_W-1:0]       m_tdata_o,
  output arc_pkg::arc_stat_t                    stat_o
);

  // Request registers
  arc_pkg::kind_e        kind_q;
  logic [KEY_BITS-1:0]   key_q;
  logic [RIGHT_BITS-1:0] right_q;

  arc_pkg::kind_e in_kind;
  assign in_kind = arc_pkg::kind_e'(s_tuser_i);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q  <= in_kind;
      // wildcard rules carry an all-zero key
      key_q   <= (in_kind == arc_pkg::KIND_ADD_WILD) ? '0
                                                     : s_tdata_i[arc_pkg::KEY_LSB +: KEY_BITS];
      right_q <= s_tdata_i[arc_pkg::RIGHT_LSB +: RIGHT_BITS];
    end
  end

  // Entry state
  logic [ENTRIES-1:0]    valid_q;
  logic [RIGHT_BITS-1:0] ent_right_q [ENTRIES];
  logic                  ent_wild_q  [ENTRIES];

  // Scan flags
  logic             hit_q;
  logic [IDX_W-1:0] hit_idx_q;
  logic             free_q;
  logic [IDX_W-1:0] free_idx_q;

  // Compare stage works on the RAM read data in the cycle after the read
  logic             cmp_en_q;
  logic [IDX_W-1:0] cmp_idx_q;
  logic [KEY_BITS-1:0] ram_rdata;

  logic wr_en;
  logic clr_one;
  logic clr_all;

  arc_ram #(
    .WIDTH (KEY_BITS),
    .DEPTH (ENTRIES),
    .AW    (IDX_W)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (free_idx_q),
    .wdata_i (key_q),
    .re_i    (cmd_i.rd),
    .raddr_i (idx_i),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmp_en_q <= 1'b0;
    end else begin
      cmp_en_q <= cmd_i.rd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      cmp_idx_q <= idx_i;
    end
  end

  logic use_wild;
  logic right_eq;
  logic exact_m;
  logic wild_m;
  logic match;

  always_comb begin
    use_wild = (kind_q == arc_pkg::KIND_ADD_WILD) || (kind_q == arc_pkg::KIND_QUERY);
    right_eq = (ent_right_q[cmp_idx_q] == right_q);
    exact_m  = valid_q[cmp_idx_q] && right_eq && (ram_rdata == key_q);
    wild_m   = valid_q[cmp_idx_q] && ent_wild_q[cmp_idx_q] && right_eq;
    match    = exact_m || (use_wild && wild_m);
  end

  // Keep the first match and the lowest free entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q  <= 1'b0;
      free_q <= 1'b0;
    end else if (cmd_i.load) begin
      hit_q  <= 1'b0;
      free_q <= 1'b0;
    end else if (cmp_en_q) begin
      if (match && !hit_q) begin
        hit_q <= 1'b1;
      end
      if (!valid_q[cmp_idx_q] && !free_q) begin
        free_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmp_en_q && match && !hit_q) begin
      hit_idx_q <= cmp_idx_q;
    end
    if (cmp_en_q && !valid_q[cmp_idx_q] && !free_q) begin
      free_idx_q <= cmp_idx_q;
    end
  end

  // Commit decision
  arc_pkg::status_e status_d;
  logic             allowed_d;

  always_comb begin
    status_d  = arc_pkg::STATUS_OK;
    allowed_d = 1'b0;
    wr_en     = 1'b0;
    clr_one   = 1'b0;
    clr_all   = 1'b0;
    unique case (kind_q)
      arc_pkg::KIND_ADD_ID, arc_pkg::KIND_ADD_WILD: begin
        if (hit_q) begin
          status_d = arc_pkg::STATUS_DUP;
        end else if (!free_q) begin
          status_d = arc_pkg::STATUS_FULL;
        end else begin
          wr_en = cmd_i.commit;
        end
      end
      arc_pkg::KIND_REMOVE: begin
        if (hit_q) begin
          clr_one = cmd_i.commit;
        end else begin
          status_d = arc_pkg::STATUS_NOT_FOUND;
        end
      end
      arc_pkg::KIND_QUERY: begin
        allowed_d = hit_q;
      end
      arc_pkg::KIND_CLEAR: begin
        clr_all = cmd_i.commit;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (clr_all) begin
      valid_q <= '0;
    end else if (clr_one) begin
      valid_q[hit_idx_q] <= 1'b0;
    end else if (wr_en) begin
      valid_q[free_idx_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      ent_right_q[free_idx_q] <= right_q;
      ent_wild_q[free_idx_q]  <= (kind_q == arc_pkg::KIND_ADD_WILD);
    end
  end

  // Result register
  logic             out_valid_q;
  arc_pkg::status_e out_status_q;
  logic             out_allowed_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_status_q  <= status_d;
      out_allowed_q <= allowed_d;
    end
  end

  assign stat_o.out_free = !out_valid_q || m_tready_i;
  assign m_tvalid_o      = out_valid_q;
  assign m_tdata_o       = {{arc_pkg::OUT_PAD_W{1'b0}}, out_allowed_q, out_status_q};

  `ARC_ASSERT_NEXT(a_remove_clears,
    cmd_i.commit && (kind_q == arc_pkg::KIND_REMOVE) && hit_q,
    !valid_q[$past(hit_idx_q)],
    "matched rule still valid after remove")

  `ARC_ASSERT_IMPLY(a_commit_free,
    cmd_i.commit,
    !out_valid_q || m_tready_i,
    "result overwritten before transfer")

endmodule

`default_nettype wire

[src/arc_ctrl.sv]
// Controller of the access rule table: accepts a request, sweeps the scan
// index over all entries, then commits. Depends on arc_pkg.
`default_nettype none

`include "access_rule_table_core_assert.svh"

module arc_ctrl #(
  parameter int unsigned ENTRIES = arc_pkg::ENTRIES_DEF,
  parameter int unsigned IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               s_tvalid_i,
  output logic                    s_tready_o,
  input  wire arc_pkg::arc_stat_t stat_i,
  output arc_pkg::arc_cmd_t       cmd_o,
  output logic [IDX_W-1:0]        idx_o
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_DRAIN  = 4'b0100,
    S_COMMIT = 4'b1000
  } state_e;

  localparam logic [IDX_W-1:0] LAST = IDX_W'(ENTRIES - 1);

  state_e           state_q, state_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic             in_fire;

  assign s_tready_o = (state_q == S_IDLE);
  assign in_fire    = s_tvalid_i && s_tready_o;

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          cmd_o.load = 1'b1;
          idx_d      = '0;
          state_d    = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.rd = 1'b1;
        if (idx_q == LAST) begin
          state_d = S_DRAIN;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_DRAIN: begin
        // last compare lands this cycle
        state_d = S_COMMIT;
      end
      S_COMMIT: begin
        if (stat_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  assign idx_o = idx_q;

  `ARC_ASSERT_NEXT(a_scan_start,
    in_fire,
    (state_q == S_SCAN) && (idx_q == '0) && !s_tready_o,
    "scan did not start at entry zero after accept")

  `ARC_ASSERT_IMPLY(a_drain_after_last,
    state_q == S_DRAIN,
    $past(idx_q) == LAST,
    "scan ended before the last entry")

endmodule

`default_nettype wire

[src/access_rule_table_core.sv]
// Access rule table: one request per slave-side transfer, one result per request.
// Each request sweeps the key RAM one entry per cycle: it reads every entry, then takes
// a drain step for the last compare and a commit step that loads the result register.
// The slave side reopens on the cycle after the commit, so a request is taken only after
// the previous one has committed. The result register lets the next request be accepted
// while a result waits; a request that finishes while the previous result is still held
// waits in its commit step.
// Top level; depends on arc_pkg, arc_ctrl, arc_datapath and arc_ram.
`default_nettype none

module access_rule_table_core #(
  parameter int unsigned ENTRIES    = arc_pkg::ENTRIES_DEF,
  parameter int unsigned KEY_BITS   = arc_pkg::KEY_BITS_DEF,
  parameter int unsigned RIGHT_BITS = arc_pkg::RIGHT_BITS_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // key_word0 [63:0], key_word1 [127:64], key_word2 [191:128],
  // key_word3 [255:192], right_code [259:256], zero pad [263:260]
  input  wire logic [arc_pkg::IN_TDATA_W-1:0] s_axis_tdata,
  // kind [2:0]
  input  wire logic [arc_pkg::KIND_W-1:0]     s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // status [1:0], allowed [2], zero pad [7:3]
  output logic [arc_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);

  localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  arc_pkg::arc_cmd_t  cmd;
  arc_pkg::arc_stat_t stat;
  logic [IDX_W-1:0]   idx;

  arc_ctrl #(
    .ENTRIES (ENTRIES),
    .IDX_W   (IDX_W)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .idx_o      (idx)
  );

  arc_datapath #(
    .ENTRIES    (ENTRIES),
    .KEY_BITS   (KEY_BITS),
    .RIGHT_BITS (RIGHT_BITS),
    .IDX_W      (IDX_W)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .idx_i      (idx),
    .s_tdata_i  (s_axis_tdata),
    .s_tuser_i  (s_axis_tuser),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_o  (m_axis_tdata),
    .stat_o     (stat)
  );

endmodule

`default_nettype wire
